>>> hdl/uusd_pkg.sv
package uusd_pkg;

    localparam int HDR_LEN = 10;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_GRAVE = 8'h60;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DIGIT = 8'h4E;
    localparam logic [7:0] UU_LO    = 8'd33;
    localparam logic [7:0] UU_HI    = 8'd95;

    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_NO_HEADER = 3'd1;
    localparam logic [2:0] ST_NO_DATA   = 3'd2;
    localparam logic [2:0] ST_NO_INFO   = 3'd3;
    localparam logic [2:0] ST_COMPLETE  = 3'd4;

    localparam logic [1:0] BPC_LOG2_MAX   = 2'd2;
    localparam logic [1:0] BPC_LOG2_RESET = 2'd1;

    typedef enum logic [7:0] {
        PH_HEADER    = 8'b0000_0001,
        PH_WAIT_NL   = 8'b0000_0010,
        PH_INFO      = 8'b0000_0100,
        PH_DECODE    = 8'b0000_1000,
        PH_DONE_OK   = 8'b0001_0000,
        PH_FAIL_HDR  = 8'b0010_0000,
        PH_FAIL_DATA = 8'b0100_0000,
        PH_FAIL_INFO = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic [3:0] keystream_bits;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        done_res;
        logic [2:0]  status;
        logic        trim_bytes;
        logic [31:0] line_count;
    } t_result;

    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h62;
            4'd1:    ch = 8'h65;
            4'd2:    ch = 8'h67;
            4'd3:    ch = 8'h69;
            4'd4:    ch = 8'h6E;
            4'd5:    ch = 8'h20;
            4'd6:    ch = CH_DIGIT;
            4'd7:    ch = CH_DIGIT;
            4'd8:    ch = CH_DIGIT;
            4'd9:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/uusd_stream_if.sv
interface uusd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [3:0] keystream_bits;
    logic       end_of_stream;

    modport source (output valid, output char_code, output keystream_bits,
                    output end_of_stream, input ready);
    modport sink   (input valid, input char_code, input keystream_bits,
                    input end_of_stream, output ready);
endinterface

interface uusd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        done_res;
    logic [2:0]  status;
    logic        trim_bytes;
    logic [31:0] line_count;

    modport source (output valid, output data_byte, output data_valid,
                    output done_res, output status, output trim_bytes,
                    output line_count, input ready);
    modport sink   (input valid, input data_byte, input data_valid,
                    input done_res, input status, input trim_bytes,
                    input line_count, output ready);
endinterface

>>> hdl/uusd_core.sv
module uusd_core #(
    parameter int LINE_COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  uusd_pkg::t_in_beat i_beat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    output uusd_pkg::t_result o_result
);

    uusd_pkg::t_phase            r_phase, n_phase;
    logic [3:0]                  r_hdr_pos, n_hdr_pos;
    logic [1:0]                  r_info_pos, n_info_pos;
    logic                        r_line_start, n_line_start;
    logic [2:0]                  r_chunk_idx, n_chunk_idx;
    logic [7:0]                  r_partial, n_partial;
    logic [1:0]                  r_pad, n_pad;
    logic [LINE_COUNT_WIDTH-1:0] r_lines, n_lines;
    logic [1:0]                  r_bpc_log2;

    logic [1:0] bpc_log2;
    logic [7:0] c;
    logic [3:0] chunk_raw;
    logic [3:0] chunk;
    logic [4:0] shamt;
    logic [7:0] shifted;
    logic [3:0] idx_inc;
    logic [3:0] parts;
    logic [7:0] want;
    logic       hdr_hit;
    logic       uu_ok;
    logic [7:0] dbyte;
    logic       dvalid;
    logic [63:0] lines_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc_log2 <= uusd_pkg::BPC_LOG2_RESET;
        end else if (i_cfg_we) begin
            r_bpc_log2 <= i_cfg_wdata;
        end
    end

    assign bpc_log2  = (r_bpc_log2 > uusd_pkg::BPC_LOG2_MAX) ? uusd_pkg::BPC_LOG2_MAX
                                                             : r_bpc_log2;
    assign c         = i_beat.char_code;
    assign chunk_raw = c[3:0] ^ i_beat.keystream_bits;
    always_comb begin
        case (bpc_log2)
            2'd0:    chunk = {3'b000, chunk_raw[0]};
            2'd1:    chunk = {2'b00, chunk_raw[1:0]};
            default: chunk = chunk_raw;
        endcase
    end
    assign shamt   = 5'(r_chunk_idx) << bpc_log2;
    assign shifted = {4'b0000, chunk} << shamt;
    assign idx_inc = 4'(r_chunk_idx) + 4'd1;
    assign parts   = 4'd8 >> bpc_log2;

    assign want    = uusd_pkg::hdr_char(r_hdr_pos);
    assign hdr_hit = (c == want)
                  || (want == uusd_pkg::CH_DIGIT && c >= uusd_pkg::CH_ZERO
                      && c <= uusd_pkg::CH_NINE);
    assign uu_ok   = (c == uusd_pkg::CH_GRAVE)
                  || (c >= uusd_pkg::UU_LO && c <= uusd_pkg::UU_HI);

    always_comb begin
        n_phase      = r_phase;
        n_hdr_pos    = r_hdr_pos;
        n_info_pos   = r_info_pos;
        n_line_start = r_line_start;
        n_chunk_idx  = r_chunk_idx;
        n_partial    = r_partial;
        n_pad        = r_pad;
        n_lines      = r_lines;
        dbyte        = 8'h00;
        dvalid       = 1'b0;
        unique case (r_phase)
            uusd_pkg::PH_HEADER: begin
                if (i_beat.end_of_stream) begin
                    n_phase = uusd_pkg::PH_FAIL_HDR;
                end else if (hdr_hit) begin
                    if (r_hdr_pos == 4'(uusd_pkg::HDR_LEN - 1)) begin
                        n_phase   = uusd_pkg::PH_WAIT_NL;
                        n_hdr_pos = 4'd0;
                    end else begin
                        n_hdr_pos = r_hdr_pos + 4'd1;
                    end
                end else begin
                    n_hdr_pos = 4'd0;
                end
            end
            uusd_pkg::PH_WAIT_NL: begin
                if (i_beat.end_of_stream) begin
                    n_phase = uusd_pkg::PH_FAIL_DATA;
                end else if (c == uusd_pkg::CH_LF) begin
                    n_phase = uusd_pkg::PH_INFO;
                end
            end
            uusd_pkg::PH_INFO: begin
                if (i_beat.end_of_stream || !uu_ok) begin
                    n_phase = uusd_pkg::PH_FAIL_INFO;
                end else begin
                    n_info_pos = r_info_pos + 2'd1;
                    if (n_info_pos == 2'd2) begin
                        n_pad   = c[1:0];
                        n_lines = LINE_COUNT_WIDTH'(1);
                        n_phase = uusd_pkg::PH_DECODE;
                    end
                end
            end
            uusd_pkg::PH_DECODE: begin
                if (i_beat.end_of_stream) begin
                    n_phase = uusd_pkg::PH_DONE_OK;
                end else if (c == uusd_pkg::CH_LF) begin
                    n_line_start = 1'b1;
                end else if (c == uusd_pkg::CH_GRAVE && r_line_start) begin
                    n_phase = uusd_pkg::PH_DONE_OK;
                end else if (r_line_start) begin
                    n_line_start = 1'b0;
                    if (r_lines != '1) begin
                        n_lines = r_lines + LINE_COUNT_WIDTH'(1);
                    end
                end else if (idx_inc >= parts) begin
                    dbyte       = r_partial | shifted;
                    dvalid      = 1'b1;
                    n_partial   = 8'h00;
                    n_chunk_idx = 3'd0;
                end else begin
                    n_partial   = r_partial | shifted;
                    n_chunk_idx = idx_inc[2:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uusd_pkg::PH_HEADER;
            r_hdr_pos    <= 4'd0;
            r_info_pos   <= 2'd0;
            r_line_start <= 1'b0;
            r_chunk_idx  <= 3'd0;
            r_partial    <= 8'h00;
            r_pad        <= 2'd0;
            r_lines      <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_hdr_pos    <= n_hdr_pos;
            r_info_pos   <= n_info_pos;
            r_line_start <= n_line_start;
            r_chunk_idx  <= n_chunk_idx;
            r_partial    <= n_partial;
            r_pad        <= n_pad;
            r_lines      <= n_lines;
        end
    end

    assign lines_ext = 64'(n_lines);

    always_comb begin
        o_result.data_byte  = dbyte;
        o_result.data_valid = dvalid;
        o_result.done_res   = 1'b1;
        o_result.trim_bytes = 1'b0;
        unique case (n_phase)
            uusd_pkg::PH_DONE_OK: begin
                o_result.status     = uusd_pkg::ST_COMPLETE;
                o_result.trim_bytes = (bpc_log2 == uusd_pkg::BPC_LOG2_MAX) && n_pad[1];
            end
            uusd_pkg::PH_FAIL_HDR:  o_result.status = uusd_pkg::ST_NO_HEADER;
            uusd_pkg::PH_FAIL_DATA: o_result.status = uusd_pkg::ST_NO_DATA;
            uusd_pkg::PH_FAIL_INFO: o_result.status = uusd_pkg::ST_NO_INFO;
            default: begin
                o_result.status   = uusd_pkg::ST_RUNNING;
                o_result.done_res = 1'b0;
            end
        endcase
        o_result.line_count = (lines_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                     : lines_ext[31:0];
    end

endmodule

>>> hdl/uu_stego_stream_decoder.sv
// Streaming decoder for data hidden in a uuencode-style text.
// Input channel i_in: one character beat per transfer, with the keystream
// bits for that character and an end_of_stream flag (a beat with the flag
// set carries no character and closes the stream).
// Output channel o_out: exactly one result beat for every input beat, in
// order: a recovered byte with data_valid, plus done_res, status, trim_bytes
// and the running line count.
// Configuration: i_cfg_we with i_cfg_wdata writes bits_per_char_log2
// (1, 2 or 4 hidden bits per character); write only while the block is idle.
// The result beat is registered and appears in the cycle after its input
// beat is accepted; throughput is one beat per cycle while the receiver
// does not stall, set by the single result register.
// A stalled receiver holds the result register; the input accepts a new
// beat only when that register is empty or being drained in the same cycle.
// Synchronous active-low reset returns the decoder to header search, clears
// the output valid flag and sets bits_per_char_log2 to one. After the stream
// stops every beat returns the final status until reset.
module uu_stego_stream_decoder #(
    parameter int LINE_COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uusd_in_if.sink    i_in,
    uusd_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    uusd_pkg::t_in_beat beat;
    uusd_pkg::t_result  result;
    uusd_pkg::t_result  r_result;
    logic               r_out_valid;
    logic               accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign beat.char_code      = i_in.char_code;
    assign beat.keystream_bits = i_in.keystream_bits;
    assign beat.end_of_stream  = i_in.end_of_stream;

    uusd_core #(
        .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_beat     (beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data_byte  = r_result.data_byte;
    assign o_out.data_valid = r_result.data_valid;
    assign o_out.done_res   = r_result.done_res;
    assign o_out.status     = r_result.status;
    assign o_out.trim_bytes = r_result.trim_bytes;
    assign o_out.line_count = r_result.line_count;

endmodule
